// ===== rtl/esc_pkg.sv =====
// Shared types, constants and helper functions for the environmental sensor
// compensation core. No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_CAL_TEMP       = 3'd0;
  localparam logic [2:0] REG_CAL_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_CAL_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_CAL_MIXED      = 3'd3;
  localparam logic [2:0] REG_CAL_HUM        = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Pipeline depths
  localparam int DIV_BITS  = 64;
  localparam int DIV_LAT   = DIV_BITS + 2;
  localparam int TEMP_LAT  = 3;
  localparam int PRE_LAT   = 4;
  localparam int POST_LAT  = 4;
  localparam int PRESS_LAT = PRE_LAT + DIV_LAT + POST_LAT;
  localparam int HUM_LAT   = 7;
  localparam int HUM_ALIGN = PRESS_LAT - HUM_LAT;
  localparam int CORE_LAT  = TEMP_LAT + PRESS_LAT;

  // Formula constants
  localparam logic [32:0] P_TFINE_OFS  = 33'd128000;
  localparam logic [63:0] P_ADC_BASE   = 64'd1048576;
  localparam logic [63:0] P_SCALE      = 64'd3125;
  localparam logic [63:0] P_P1_BASE    = 64'h0000_8000_0000_0000;
  localparam logic [31:0] H_TFINE_OFS  = 32'd76800;
  localparam logic [31:0] H_ROUND_X    = 32'd16384;
  localparam logic [31:0] H_Y_OFS      = 32'd32768;
  localparam logic [31:0] H_Y_BASE     = 32'd2097152;
  localparam logic [31:0] H_ROUND_Y    = 32'd8192;
  localparam logic signed [31:0] H_MAX = 32'sd419430400;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic [31:0] temp_centideg;
    logic [31:0] pressure_q24_8;
    logic [16:0] humidity_q22_10;
  } out_item_t;

  // Decoded calibration words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } cal_t;

  // Temperature front end output
  typedef struct packed {
    logic        valid;
    logic [31:0] tfine;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
  } tstage_t;

  // Control travelling alongside the divider
  typedef struct packed {
    logic valid;
    logic zero;
  } div_side_t;

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    sx16_64 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx16_32(input logic [15:0] v);
    sx16_32 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12_32(input logic [11:0] v);
    sx12_32 = {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(input logic [7:0] v);
    sx8_32 = {{24{v[7]}}, v};
  endfunction

endpackage

// ===== rtl/esc_temp.sv =====
// Temperature front end: raw temperature to fine temperature, three stages.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_temp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  esc_pkg::in_item_t in_item,
  input  esc_pkg::cal_t     cal,
  output esc_pkg::tstage_t  out_stage
);

  logic [31:0] ta, td, dsh;
  logic [31:0] amul_nxt, dd_nxt, a_nxt, bm_nxt, tfine_nxt;
  logic [31:0] amul_r, dd_r, a_r, bm_r, tfine_r;
  logic [2:0]  vld_r;
  logic [19:0] rp_r [0:2];
  logic [15:0] rh_r [0:2];

  // Stage 1: linear and square terms
  always_comb begin
    ta       = {15'd0, in_item.raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0};
    td       = {16'd0, in_item.raw_temperature[19:4]} - {16'd0, cal.t1};
    amul_nxt = ta * esc_pkg::sx16_32(cal.t2);
    dd_nxt   = td * td;
  end

  // Stage 2: scale
  always_comb begin
    a_nxt  = $signed(amul_r) >>> 11;
    dsh    = $signed(dd_r) >>> 12;
    bm_nxt = dsh * esc_pkg::sx16_32(cal.t3);
  end

  // Stage 3: fine temperature
  always_comb begin
    tfine_nxt = a_r + 32'($signed(bm_r) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    amul_r  <= amul_nxt;
    dd_r    <= dd_nxt;
    a_r     <= a_nxt;
    bm_r    <= bm_nxt;
    tfine_r <= tfine_nxt;
    rp_r[0] <= in_item.raw_pressure;
    rh_r[0] <= in_item.raw_humidity;
    rp_r[1] <= rp_r[0];
    rh_r[1] <= rh_r[0];
    rp_r[2] <= rp_r[1];
    rh_r[2] <= rh_r[1];
  end

  assign out_stage.valid = vld_r[2];
  assign out_stage.tfine = tfine_r;
  assign out_stage.raw_p = rp_r[2];
  assign out_stage.raw_h = rh_r[2];

endmodule

// ===== rtl/esc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [63:0]         num,
  input  logic [63:0]         den,
  input  esc_pkg::div_side_t  side_in,
  output logic [63:0]         quo,
  output esc_pkg::div_side_t  side_out
);

  localparam int N = esc_pkg::DIV_BITS;

  logic [N-1:0]       rem_r [0:N];
  logic [N-1:0]       nq_r  [0:N];
  logic [N-1:0]       dv_r  [0:N];
  logic               neg_r [0:N];
  esc_pkg::div_side_t sd_r  [0:N];
  logic [N-1:0]       quo_r;
  esc_pkg::div_side_t sdo_r;

  // Entry: magnitudes and result sign
  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    nq_r[0]  <= num[N-1] ? (~num + 1'b1) : num;
    dv_r[0]  <= den[N-1] ? (~den + 1'b1) : den;
    neg_r[0] <= num[N-1] ^ den[N-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r[0] <= '0;
    end else begin
      sd_r[0] <= side_in;
    end
  end

  // Restoring iterations
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [N:0] rr, diff;
    logic       ge;

    always_comb begin
      rr   = {rem_r[i], nq_r[i][N-1]};
      diff = rr - {1'b0, dv_r[i]};
      ge   = !diff[N];
    end

    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? diff[N-1:0] : rr[N-1:0];
      nq_r[i+1]  <= {nq_r[i][N-2:0], ge};
      dv_r[i+1]  <= dv_r[i];
      neg_r[i+1] <= neg_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[i+1] <= '0;
      end else begin
        sd_r[i+1] <= sd_r[i];
      end
    end
  end

  // Sign fix
  always_ff @(posedge clk) begin
    quo_r <= neg_r[N] ? (~nq_r[N] + 1'b1) : nq_r[N];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdo_r <= '0;
    end else begin
      sdo_r <= sd_r[N];
    end
  end

  assign quo      = quo_r;
  assign side_out = sdo_r;

endmodule

// ===== rtl/esc_press.sv =====
// Pressure path: 64-bit pre-divide terms, divider, post-divide correction.
// Depends on esc_pkg and esc_div.
`timescale 1ns / 1ps

module esc_press (
  input  logic             clk,
  input  logic             rst_n,
  input  esc_pkg::tstage_t in_stage,
  input  esc_pkg::cal_t    cal,
  output logic             out_valid,
  output logic [31:0]      pressure
);

  logic signed [32:0] q1s;
  logic signed [65:0] sq_full;
  logic signed [48:0] m5_full, m2_full;
  logic [63:0] sq_nxt, m5_nxt, m2_nxt;
  logic [63:0] sq_r, m5_r, m2_r;
  logic [63:0] q2a_nxt, q1a_nxt, q2a_r, q1a_r, m5b_r, m2b_r;
  logic [63:0] q2_nxt, q1b_nxt, q2_r, q1b_r;
  logic [63:0] pp, q1c_nxt, num_nxt, q1c_r, num_r;
  logic [63:0] dvs;
  logic [19:0] rp_r [0:2];
  logic [3:0]  vld_r;
  esc_pkg::div_side_t side_in, side_out;
  logic [63:0] quo;

  // Pre 0: offset fine temperature, square and linear products
  always_comb begin
    q1s     = $signed({in_stage.tfine[31], in_stage.tfine}) - $signed(esc_pkg::P_TFINE_OFS);
    sq_full = q1s * q1s;
    m5_full = q1s * $signed(cal.p5);
    m2_full = q1s * $signed(cal.p2);
    sq_nxt  = sq_full[63:0];
    m5_nxt  = 64'(m5_full);
    m2_nxt  = 64'(m2_full);
  end

  // Pre 1: scale square by P6 and P3
  always_comb begin
    q2a_nxt = sq_r * esc_pkg::sx16_64(cal.p6);
    q1a_nxt = sq_r * esc_pkg::sx16_64(cal.p3);
  end

  // Pre 2: sum the terms
  always_comb begin
    q2_nxt  = q2a_r + (m5b_r << 17) + (esc_pkg::sx16_64(cal.p4) << 35);
    q1b_nxt = 64'($signed(q1a_r) >>> 8) + (m2b_r << 12);
  end

  // Pre 3: divisor product and numerator
  always_comb begin
    q1c_nxt = (esc_pkg::P_P1_BASE + q1b_r) * {48'd0, cal.p1};
    pp      = esc_pkg::P_ADC_BASE - {44'd0, rp_r[2]};
    num_nxt = ((pp << 31) - q2_r) * esc_pkg::P_SCALE;
  end

  always_ff @(posedge clk) begin
    sq_r    <= sq_nxt;
    m5_r    <= m5_nxt;
    m2_r    <= m2_nxt;
    q2a_r   <= q2a_nxt;
    q1a_r   <= q1a_nxt;
    m5b_r   <= m5_r;
    m2b_r   <= m2_r;
    q2_r    <= q2_nxt;
    q1b_r   <= q1b_nxt;
    q1c_r   <= q1c_nxt;
    num_r   <= num_nxt;
    rp_r[0] <= in_stage.raw_p;
    rp_r[1] <= rp_r[0];
    rp_r[2] <= rp_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_stage.valid};
    end
  end

  // Divide
  assign dvs           = $signed(q1c_r) >>> 33;
  assign side_in.valid = vld_r[3];
  assign side_in.zero  = (dvs == '0);

  esc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .num      (num_r),
    .den      (dvs),
    .side_in  (side_in),
    .quo      (quo),
    .side_out (side_out)
  );

  logic [63:0] ps, m9a_nxt, q2m_nxt;
  logic [63:0] p0_r, ps_r, m9a_r, q2m_r;
  logic [63:0] ma_nxt, ma_r, p1_r, q2p_r;
  logic [31:0] mb_nxt, mc_nxt, mb_r, mc_r;
  logic [63:0] m9, q1p_nxt, q1p_r, p2_r, q2p2_r;
  logic [63:0] psum, pfin;
  logic [31:0] pres_nxt, pres_r;
  esc_pkg::div_side_t ps0_r, ps1_r, ps2_r, ps3_r;

  // Post 0: P9 and P8 products
  always_comb begin
    ps      = $signed(quo) >>> 13;
    m9a_nxt = esc_pkg::sx16_64(cal.p9) * ps;
    q2m_nxt = esc_pkg::sx16_64(cal.p8) * quo;
  end

  // Post 1: 64-bit wrapping product split into 32-bit partials
  always_comb begin
    ma_nxt = {32'd0, m9a_r[31:0]} * {32'd0, ps_r[31:0]};
    mb_nxt = m9a_r[31:0] * ps_r[63:32];
    mc_nxt = m9a_r[63:32] * ps_r[31:0];
  end

  // Post 2: recombine partials
  always_comb begin
    m9      = ma_r + {mb_r + mc_r, 32'd0};
    q1p_nxt = $signed(m9) >>> 25;
  end

  // Post 3: final sum, zero divisor gives zero
  always_comb begin
    psum     = p2_r + q1p_r + q2p2_r;
    pfin     = 64'($signed(psum) >>> 8) + (esc_pkg::sx16_64(cal.p7) << 4);
    pres_nxt = ps2_r.zero ? 32'd0 : pfin[31:0];
  end

  always_ff @(posedge clk) begin
    p0_r   <= quo;
    ps_r   <= ps;
    m9a_r  <= m9a_nxt;
    q2m_r  <= q2m_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    mc_r   <= mc_nxt;
    p1_r   <= p0_r;
    q2p_r  <= $signed(q2m_r) >>> 19;
    q1p_r  <= q1p_nxt;
    p2_r   <= p1_r;
    q2p2_r <= q2p_r;
    pres_r <= pres_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps0_r <= '0;
      ps1_r <= '0;
      ps2_r <= '0;
      ps3_r <= '0;
    end else begin
      ps0_r <= side_out;
      ps1_r <= ps0_r;
      ps2_r <= ps1_r;
      ps3_r <= ps2_r;
    end
  end

  assign out_valid = ps3_r.valid;
  assign pressure  = pres_r;

endmodule

// ===== rtl/esc_hum.sv =====
// Humidity path and temperature output, 32-bit wrapping, aligned to the
// pressure path by a delay line. Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_hum (
  input  logic             clk,
  input  esc_pkg::tstage_t in_stage,
  input  esc_pkg::cal_t    cal,
  output logic [31:0]      temp,
  output logic [16:0]      humidity
);

  logic [31:0] v, tmul;
  logic [31:0] xm_r, y1m_r, vh3_r;
  logic [15:0] rh_r;
  logic [31:0] t_r [0:esc_pkg::HUM_LAT-1];
  logic [31:0] xin, y1, yf;
  logic [31:0] x_r, ym_r, x2_r, yh_r, y2;
  logic [31:0] y, vv_r, s, ss_r, vv2_r, w_r, vv3_r, v2;
  logic [16:0] h_nxt, h_r;

  // Stage 0: temperature result and first products
  always_comb begin
    v    = in_stage.tfine - esc_pkg::H_TFINE_OFS;
    tmul = (in_stage.tfine << 2) + in_stage.tfine + 32'd128;
  end

  always_ff @(posedge clk) begin
    t_r[0] <= $signed(tmul) >>> 8;
    xm_r   <= esc_pkg::sx12_32(cal.h5) * v;
    y1m_r  <= v * esc_pkg::sx8_32(cal.h6);
    vh3_r  <= v * {24'd0, cal.h3};
    rh_r   <= in_stage.raw_h;
  end

  // Stage 1: x term and first y product
  always_comb begin
    xin = {2'd0, rh_r, 14'd0} - (esc_pkg::sx12_32(cal.h4) << 20) - xm_r
          + esc_pkg::H_ROUND_X;
    y1  = $signed(y1m_r) >>> 10;
    yf  = 32'($signed(vh3_r) >>> 11) + esc_pkg::H_Y_OFS;
  end

  always_ff @(posedge clk) begin
    x_r  <= $signed(xin) >>> 15;
    ym_r <= y1 * yf;
  end

  // Stage 2: H2 product
  assign y2 = 32'($signed(ym_r) >>> 10) + esc_pkg::H_Y_BASE;

  always_ff @(posedge clk) begin
    x2_r <= x_r;
    yh_r <= y2 * esc_pkg::sx16_32(cal.h2);
  end

  // Stage 3: x times y
  assign y = $signed(yh_r + esc_pkg::H_ROUND_Y) >>> 14;

  always_ff @(posedge clk) begin
    vv_r <= x2_r * y;
  end

  // Stage 4: square of scaled value
  assign s = $signed(vv_r) >>> 15;

  always_ff @(posedge clk) begin
    ss_r  <= s * s;
    vv2_r <= vv_r;
  end

  // Stage 5: H1 product
  always_ff @(posedge clk) begin
    w_r   <= 32'($signed(ss_r) >>> 7) * {24'd0, cal.h1};
    vv3_r <= vv2_r;
  end

  // Stage 6: subtract, clamp and scale
  always_comb begin
    v2 = vv3_r - 32'($signed(w_r) >>> 4);
    if ($signed(v2) < 0) begin
      h_nxt = '0;
    end else if ($signed(v2) > esc_pkg::H_MAX) begin
      h_nxt = esc_pkg::H_MAX[28:12];
    end else begin
      h_nxt = v2[28:12];
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

  for (genvar i = 1; i < esc_pkg::HUM_LAT; i++) begin : g_tdly
    always_ff @(posedge clk) begin
      t_r[i] <= t_r[i-1];
    end
  end

  // Alignment delay to the pressure path
  logic [31:0] at_r [0:esc_pkg::HUM_ALIGN-1];
  logic [16:0] ah_r [0:esc_pkg::HUM_ALIGN-1];

  always_ff @(posedge clk) begin
    at_r[0] <= t_r[esc_pkg::HUM_LAT-1];
    ah_r[0] <= h_r;
  end

  for (genvar i = 1; i < esc_pkg::HUM_ALIGN; i++) begin : g_adly
    always_ff @(posedge clk) begin
      at_r[i] <= at_r[i-1];
      ah_r[i] <= ah_r[i-1];
    end
  end

  assign temp     = at_r[esc_pkg::HUM_ALIGN-1];
  assign humidity = ah_r[esc_pkg::HUM_ALIGN-1];

endmodule

// ===== rtl/env_sensor_compensation_core.sv =====
// Top level of the sensor compensation core: calibration registers and the
// three pipelines. Depends on esc_pkg, esc_temp, esc_press, esc_hum.
`timescale 1ns / 1ps

// Usage
// Input: drive in_data and raise start; an item is taken at each rising edge
// with start high and busy low. busy is high only during reset and the cycle
// after it, so a new item can enter every cycle.
// Output: each item gives one result on out_data, marked by out_valid for a
// single cycle, after 3 temperature stages, 4 pre-divide stages, 66 divider
// stages and 4 post-divide stages. The receiver cannot stall the core;
// results must be taken as they appear.
// Throughput: one item per cycle, set by the fully pipelined 64-bit divider
// (one quotient bit per stage).
// Configuration: cfg_we with cfg_index and cfg_wdata writes one of the five
// calibration registers; unknown indexes are ignored. Write only while no
// item is in flight.
// Reset: synchronous, active low; clears calibration registers and all
// valid bits, so no stale result appears afterwards.

module env_sensor_compensation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  esc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  output esc_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [47:0] cal_temp_r, cal_mixed_r;
  logic [63:0] cal_press_low_r, cal_press_high_r;
  logic [31:0] cal_hum_r;
  logic        busy_r;
  esc_pkg::cal_t    cal;
  esc_pkg::tstage_t tst;
  logic        accept;
  logic [31:0] pressure, temp;
  logic [16:0] humidity;

  // Calibration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r       <= '0;
      cal_press_low_r  <= '0;
      cal_press_high_r <= '0;
      cal_mixed_r      <= '0;
      cal_hum_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esc_pkg::REG_CAL_TEMP:       cal_temp_r       <= cfg_wdata[47:0];
        esc_pkg::REG_CAL_PRESS_LOW:  cal_press_low_r  <= cfg_wdata;
        esc_pkg::REG_CAL_PRESS_HIGH: cal_press_high_r <= cfg_wdata;
        esc_pkg::REG_CAL_MIXED:      cal_mixed_r      <= cfg_wdata[47:0];
        esc_pkg::REG_CAL_HUM:        cal_hum_r        <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // Field decode
  always_comb begin
    cal.t1 = cal_temp_r[15:0];
    cal.t2 = cal_temp_r[31:16];
    cal.t3 = cal_temp_r[47:32];
    cal.p1 = cal_press_low_r[15:0];
    cal.p2 = cal_press_low_r[31:16];
    cal.p3 = cal_press_low_r[47:32];
    cal.p4 = cal_press_low_r[63:48];
    cal.p5 = cal_press_high_r[15:0];
    cal.p6 = cal_press_high_r[31:16];
    cal.p7 = cal_press_high_r[47:32];
    cal.p8 = cal_press_high_r[63:48];
    cal.p9 = cal_mixed_r[15:0];
    cal.h1 = cal_mixed_r[23:16];
    cal.h2 = cal_mixed_r[39:24];
    cal.h3 = cal_mixed_r[47:40];
    cal.h4 = cal_hum_r[11:0];
    cal.h5 = cal_hum_r[23:12];
    cal.h6 = cal_hum_r[31:24];
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  esc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_data),
    .cal       (cal),
    .out_stage (tst)
  );

  esc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stage  (tst),
    .cal       (cal),
    .out_valid (out_valid),
    .pressure  (pressure)
  );

  esc_hum u_hum (
    .clk      (clk),
    .in_stage (tst),
    .cal      (cal),
    .temp     (temp),
    .humidity (humidity)
  );

  assign out_data.temp_centideg   = temp;
  assign out_data.pressure_q24_8  = pressure;
  assign out_data.humidity_q22_10 = humidity;

endmodule

// ===== rtl/esc_checker.sv =====
// Port-level checks for the compensation core, bound to the top level.
// Depends on esc_pkg and env_sensor_compensation_core.
`timescale 1ns / 1ps

module esc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input esc_pkg::out_item_t out_data
);

  // Every result stems from an item taken a fixed latency earlier
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, esc_pkg::CORE_LAT))
    else $error("result without a matching item");

  // Every item gives a result after the fixed latency
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(esc_pkg::CORE_LAT) out_valid)
    else $error("item lost");

  // Humidity stays within its clamp
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.humidity_q22_10 <= 17'd102400))
    else $error("humidity out of range");

  // Busy only follows reset
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

endmodule

bind env_sensor_compensation_core esc_checker u_esc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
